FILE: rtl/ffra_pkg.sv
// ----------------------------------------------------------------------------
// ffra_pkg
// Shared codes and field widths for the first-fit region allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package ffra_pkg;

    // Fixed widths of the command and result words
    localparam int FIELD_W   = 48;
    localparam int CMD_W     = 2;
    localparam int STATUS_W  = 2;
    localparam int CFG_IDX_W = 1;

    typedef logic [CMD_W-1:0]     t_cmd;
    typedef logic [STATUS_W-1:0]  t_status;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    typedef logic [FIELD_W-1:0]   t_field;

    // Commands
    localparam t_cmd CMD_ALLOC    = 2'd0;
    localparam t_cmd CMD_ALLOC_AT = 2'd1;
    localparam t_cmd CMD_FREE     = 2'd2;

    // Result status
    localparam t_status ST_OK       = 2'd0;
    localparam t_status ST_NOSPACE  = 2'd1;
    localparam t_status ST_FULL     = 2'd2;
    localparam t_status ST_NOTFOUND = 2'd3;

    // Configuration register indexes
    localparam t_cfg_idx CFG_WINDOW_BASE   = 1'b0;
    localparam t_cfg_idx CFG_WINDOW_LENGTH = 1'b1;

endpackage

`default_nettype wire

FILE: rtl/first_fit_region_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_region_allocator
// First-fit allocator of page-rounded regions inside an address window.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: i_cmd, i_req_address, i_req_length are taken at a rising
//   edge where start is high and busy is low. busy stays high until the
//   result word has been launched.
//   Result channel: o_status, o_region_base, o_region_length are valid for
//   exactly one cycle, flagged by o_done. The receiver cannot stall; a
//   word not taken on that cycle is gone.
//   Config port: i_cfg_we / i_cfg_index / i_cfg_wdata write the window base
//   (index 0) and window length (index 1); write only while busy is low.
//   Flow: a command rejected up front (full table, empty table on a free,
//   rounding overflow, unknown command) answers from S_CHECK, after S_PREP.
//   A search walks the stored regions at one per cycle; an insert or a
//   removal then shifts the tail of the table at one entry per cycle.
//   Worst case is an allocate-at that scans MAX_REGIONS-1 entries and then
//   shifts all of them up. Throughput is set by the single read port of the
//   region table memory, which both the search and the shift walk through.
//   Reset: synchronous, active low. Clears the region count and the window
//   registers; table contents are left as is and never read before written.
// ----------------------------------------------------------------------------
`default_nettype none

module first_fit_region_allocator
    import ffra_pkg::*;
#(
    parameter int MAX_REGIONS = 16,
    parameter int PAGE_SHIFT  = 12,
    parameter int ADDR_BITS   = 48
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    // command
    input  wire logic     start,
    output logic          busy,
    input  wire t_cmd     i_cmd,
    input  wire t_field   i_req_address,
    input  wire t_field   i_req_length,
    // result
    output logic          o_done,
    output t_status       o_status,
    output t_field        o_region_base,
    output t_field        o_region_length,
    // config
    input  wire logic     i_cfg_we,
    input  wire t_cfg_idx i_cfg_index,
    input  wire t_field   i_cfg_wdata
);

    localparam int AW = ADDR_BITS;
    localparam int IW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
    localparam int CW = $clog2(MAX_REGIONS + 1);

    // Page mask and rounding limit, worked out wide so any PAGE_SHIFT fits
    localparam logic [64:0] PGM_WIDE   = (65'd1 << PAGE_SHIFT) - 65'd1;
    localparam logic [64:0] AMASK_WIDE = (65'd1 << AW) - 65'd1;
    localparam bit          ROUND_OK   = (PGM_WIDE <= AMASK_WIDE);
    localparam logic [AW-1:0] PG_MASK   = AW'(PGM_WIDE);
    localparam logic [AW-1:0] RND_LIMIT = ROUND_OK ? AW'(AMASK_WIDE - PGM_WIDE) : '0;
    localparam logic [AW-1:0] ADDR_MAX  = '1;
    localparam logic [CW-1:0] COUNT_MAX = CW'(MAX_REGIONS);

    // Sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PREP  = 3'd1;  // wide sums
    localparam logic [2:0] S_CHECK = 3'd2;  // rounding, early rejects
    localparam logic [2:0] S_SCAN  = 3'd3;  // walk the table
    localparam logic [2:0] S_TAIL  = 3'd4;  // gap after the last region
    localparam logic [2:0] S_INS   = 3'd5;  // shift up from the end, drop new entry in
    localparam logic [2:0] S_PUT   = 3'd6;  // write new entry at slot 0 / empty table
    localparam logic [2:0] S_REM   = 3'd7;  // shift down over the freed slot

    typedef struct packed {
        logic [AW-1:0] base;
        logic [AW-1:0] len;
    } t_entry;

    // ------------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------------
    logic [2:0]    r_state, n_state;
    t_cmd          r_cmd;
    logic [AW-1:0] r_addr, r_len;
    logic [AW-1:0] r_wbase, r_wlen;
    logic [CW-1:0] r_count, n_count;

    logic [AW:0]   r_sum;       // addr + len
    logic [AW:0]   r_osum;      // page offset of addr + len
    logic [AW-1:0] r_wend;      // saturated window end
    logic          r_rlen_ok;
    logic [AW-1:0] r_rlen;      // length rounded up to pages

    logic [AW-1:0] r_nbase, n_nbase;   // new region
    logic [AW-1:0] r_nlen, n_nlen;
    logic [AW-1:0] r_end, n_end;       // allocate-at end bound
    logic [AW-1:0] r_cursor, n_cursor; // first-fit running end

    logic [CW-1:0] r_rd_idx, n_rd_idx;
    logic [IW-1:0] r_put_idx, n_put_idx;

    // table memory, one read and one write port
    t_entry        mem [MAX_REGIONS];
    logic          rd_en;
    logic [IW-1:0] rd_addr;
    logic          wr_en;
    logic [IW-1:0] wr_addr;
    t_entry        wr_data;
    t_entry        r_q;
    logic          r_q_vld;
    logic [IW-1:0] r_q_idx;

    // scan stage A: end and clamped gap end of one entry
    logic          r_a_vld;
    logic [IW-1:0] r_a_idx;
    logic [AW-1:0] r_a_base, r_a_end, r_a_gend;

    // result word
    logic          r_done;
    t_status       r_status;
    t_field        r_out_base, r_out_len;

    // ------------------------------------------------------------------------
    // Datapath helpers
    // ------------------------------------------------------------------------
    logic [AW:0]   prep_wsum;
    logic [AW:0]   a_sum;
    logic [AW-1:0] a_end, a_gend;
    logic          chk_end_ok;
    logic [AW-1:0] chk_end, chk_olen, chk_start;
    logic          b_fit, b_overlap, b_match, b_last, b_hit;
    logic          tail_fit;
    logic [IW-1:0] last_idx;
    logic          q_above;

    assign prep_wsum = {1'b0, r_wbase} + {1'b0, r_wlen};

    assign a_sum  = {1'b0, r_q.base} + {1'b0, r_q.len};
    assign a_end  = a_sum[AW] ? ADDR_MAX : a_sum[AW-1:0];
    assign a_gend = (r_q.base < r_wend) ? r_q.base : r_wend;

    assign chk_end_ok = ROUND_OK && !r_sum[AW] && (r_sum[AW-1:0] <= RND_LIMIT);
    assign chk_end    = (r_sum[AW-1:0] + PG_MASK) & ~PG_MASK;
    // end - start equals the rounded sum of the page offset and the length
    assign chk_olen   = (r_osum[AW-1:0] + PG_MASK) & ~PG_MASK;
    assign chk_start  = r_addr & ~PG_MASK;

    assign last_idx  = IW'(r_count - CW'(1));
    assign b_fit     = {1'b0, r_a_gend} >= ({1'b0, r_cursor} + {1'b0, r_nlen});
    assign b_overlap = (r_nbase < r_a_end) && (r_end > r_a_base);
    assign b_match   = (r_a_base == r_addr);
    assign b_last    = (r_a_idx == last_idx);
    assign tail_fit  = {1'b0, r_wend} >= ({1'b0, r_cursor} + {1'b0, r_nlen});
    assign q_above   = r_q.base > r_nbase;

    always_comb begin
        case (r_cmd)
            CMD_ALLOC:    b_hit = b_fit;
            CMD_ALLOC_AT: b_hit = b_overlap;
            default:      b_hit = b_match;
        endcase
    end

    // ------------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------------
    logic    fin;
    t_status fin_status;
    logic    fin_region;

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_nbase    = r_nbase;
        n_nlen     = r_nlen;
        n_end      = r_end;
        n_cursor   = r_cursor;
        n_rd_idx   = r_rd_idx;
        n_put_idx  = r_put_idx;
        rd_en      = 1'b0;
        rd_addr    = r_rd_idx[IW-1:0];
        wr_en      = 1'b0;
        wr_addr    = r_put_idx;
        wr_data    = '{base: r_nbase, len: r_nlen};
        fin        = 1'b0;
        fin_status = ST_OK;
        fin_region = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_PREP;
                end
            end

            S_PREP: begin
                n_state = S_CHECK;
            end

            S_CHECK: begin
                case (r_cmd)
                    CMD_ALLOC: begin
                        if (r_count >= COUNT_MAX) begin
                            fin        = 1'b1;
                            fin_status = ST_FULL;
                        end else if (!r_rlen_ok) begin
                            fin        = 1'b1;
                            fin_status = ST_NOSPACE;
                        end else begin
                            n_nlen   = r_rlen;
                            n_cursor = r_wbase;
                            n_rd_idx = '0;
                            n_state  = (r_count == '0) ? S_TAIL : S_SCAN;
                        end
                    end
                    CMD_ALLOC_AT: begin
                        if (r_count >= COUNT_MAX) begin
                            fin        = 1'b1;
                            fin_status = ST_FULL;
                        end else if (!chk_end_ok) begin
                            fin        = 1'b1;
                            fin_status = ST_NOSPACE;
                        end else begin
                            n_nbase = chk_start;
                            n_nlen  = chk_olen;
                            n_end   = chk_end;
                            if (r_count == '0) begin
                                n_put_idx = '0;
                                n_state   = S_PUT;
                            end else begin
                                n_rd_idx = '0;
                                n_state  = S_SCAN;
                            end
                        end
                    end
                    CMD_FREE: begin
                        if (r_count == '0) begin
                            fin        = 1'b1;
                            fin_status = ST_NOTFOUND;
                        end else begin
                            n_rd_idx = '0;
                            n_state  = S_SCAN;
                        end
                    end
                    default: begin
                        fin        = 1'b1;
                        fin_status = ST_NOSPACE;
                    end
                endcase
            end

            S_SCAN: begin
                // stop issuing once stage B has decided
                if (!(r_a_vld && (b_hit || b_last)) && (r_rd_idx < r_count)) begin
                    rd_en    = 1'b1;
                    n_rd_idx = r_rd_idx + CW'(1);
                end
                if (r_a_vld) begin
                    case (r_cmd)
                        CMD_ALLOC: begin
                            if (b_fit) begin
                                n_nbase  = r_cursor;
                                n_rd_idx = r_count;
                                n_state  = S_INS;
                            end else begin
                                if (r_a_end > r_cursor) begin
                                    n_cursor = r_a_end;
                                end
                                if (b_last) begin
                                    n_state = S_TAIL;
                                end
                            end
                        end
                        CMD_ALLOC_AT: begin
                            if (b_overlap) begin
                                fin        = 1'b1;
                                fin_status = ST_NOSPACE;
                            end else if (b_last) begin
                                n_rd_idx = r_count;
                                n_state  = S_INS;
                            end
                        end
                        default: begin
                            if (b_match) begin
                                if (b_last) begin
                                    n_count = r_count - CW'(1);
                                    fin     = 1'b1;
                                end else begin
                                    n_rd_idx = CW'(r_a_idx) + CW'(1);
                                    n_state  = S_REM;
                                end
                            end else if (b_last) begin
                                fin        = 1'b1;
                                fin_status = ST_NOTFOUND;
                            end
                        end
                    endcase
                end
            end

            S_TAIL: begin
                if (tail_fit) begin
                    n_nbase = r_cursor;
                    if (r_count == '0) begin
                        n_put_idx = '0;
                        n_state   = S_PUT;
                    end else begin
                        n_rd_idx = r_count;
                        n_state  = S_INS;
                    end
                end else begin
                    fin        = 1'b1;
                    fin_status = ST_NOSPACE;
                end
            end

            S_INS: begin
                // walk down from the last entry; r_rd_idx is one past the next read
                if (!(r_q_vld && !q_above) && (r_rd_idx != '0)) begin
                    rd_en    = 1'b1;
                    rd_addr  = IW'(r_rd_idx - CW'(1));
                    n_rd_idx = r_rd_idx - CW'(1);
                end
                if (r_q_vld) begin
                    wr_en   = 1'b1;
                    wr_addr = r_q_idx + IW'(1);
                    if (q_above) begin
                        wr_data = r_q;
                        if (r_q_idx == '0) begin
                            n_put_idx = '0;
                            n_state   = S_PUT;
                        end
                    end else begin
                        n_count    = r_count + CW'(1);
                        fin        = 1'b1;
                        fin_region = 1'b1;
                    end
                end
            end

            S_PUT: begin
                wr_en      = 1'b1;
                n_count    = r_count + CW'(1);
                fin        = 1'b1;
                fin_region = 1'b1;
            end

            S_REM: begin
                if (r_rd_idx < r_count) begin
                    rd_en    = 1'b1;
                    n_rd_idx = r_rd_idx + CW'(1);
                end
                if (r_q_vld) begin
                    wr_en   = 1'b1;
                    wr_addr = r_q_idx - IW'(1);
                    wr_data = r_q;
                    if (r_q_idx == last_idx) begin
                        n_count = r_count - CW'(1);
                        fin     = 1'b1;
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (fin) begin
            n_state = S_IDLE;
        end
    end

    // ------------------------------------------------------------------------
    // Table memory
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_q <= mem[rd_addr];
        end
    end

    // ------------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_q_vld <= 1'b0;
            r_a_vld <= 1'b0;
            r_done  <= 1'b0;
            r_wbase <= '0;
            r_wlen  <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_q_vld <= rd_en;
            r_a_vld <= r_q_vld && (r_state == S_SCAN) && (n_state == S_SCAN);
            r_done  <= fin;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_WINDOW_BASE:   r_wbase <= AW'(i_cfg_wdata);
                    CFG_WINDOW_LENGTH: r_wlen  <= AW'(i_cfg_wdata);
                    default: ;
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        r_nbase   <= n_nbase;
        r_nlen    <= n_nlen;
        r_end     <= n_end;
        r_cursor  <= n_cursor;
        r_rd_idx  <= n_rd_idx;
        r_put_idx <= n_put_idx;

        if (r_state == S_IDLE && start) begin
            r_cmd  <= i_cmd;
            r_addr <= AW'(i_req_address);
            r_len  <= AW'(i_req_length);
        end

        if (r_state == S_PREP) begin
            r_sum     <= {1'b0, r_addr} + {1'b0, r_len};
            r_osum    <= {1'b0, r_addr & PG_MASK} + {1'b0, r_len};
            r_wend    <= prep_wsum[AW] ? ADDR_MAX : prep_wsum[AW-1:0];
            r_rlen_ok <= ROUND_OK && (r_len <= RND_LIMIT);
            r_rlen    <= (r_len + PG_MASK) & ~PG_MASK;
        end

        if (rd_en) begin
            r_q_idx <= rd_addr;
        end

        r_a_idx  <= r_q_idx;
        r_a_base <= r_q.base;
        r_a_end  <= a_end;
        r_a_gend <= a_gend;

        if (fin) begin
            r_status   <= fin_status;
            r_out_base <= fin_region ? FIELD_W'(r_nbase) : '0;
            r_out_len  <= fin_region ? FIELD_W'(r_nlen) : '0;
        end
    end

    assign busy            = (r_state != S_IDLE);
    assign o_done          = r_done;
    assign o_status        = r_status;
    assign o_region_base   = r_out_base;
    assign o_region_length = r_out_len;

endmodule

`default_nettype wire

FILE: bench/ffra_region_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffra_region_checker
// Watches the command, result and config channels of the region allocator,
// keeps its own copy of the region table and checks every result word.
// ----------------------------------------------------------------------------
module ffra_region_checker
    import ffra_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    input  logic     i_busy,
    input  t_cmd     i_cmd,
    input  t_field   i_req_address,
    input  t_field   i_req_length,
    input  logic     i_done,
    input  t_status  i_status,
    input  t_field   i_region_base,
    input  t_field   i_region_length,
    input  logic     i_cfg_we,
    input  t_cfg_idx i_cfg_index,
    input  t_field   i_cfg_wdata,
    output int       o_fail_count,
    output int       o_pending
);

    localparam int          REGION_SLOTS = 16;
    localparam logic [63:0] ADDR_MAX     = 64'h0000_FFFF_FFFF_FFFF;
    localparam logic [63:0] PAGE_MASK    = 64'h0000_0000_0000_0FFF;

    typedef struct packed {
        t_status status;
        t_field  base;
        t_field  length;
    } t_region_reply;

    t_region_reply region_reply_q[$];

    logic [63:0] tbl_base[REGION_SLOTS];
    logic [63:0] tbl_len[REGION_SLOTS];
    int          tbl_count;
    logic [63:0] win_base;
    logic [63:0] win_len;
    int          fail_total;

    initial begin
        fail_total   = 0;
        tbl_count    = 0;
        win_base     = '0;
        win_len      = '0;
    end

    // end address, pinned at the top of the address space
    function automatic logic [63:0] clip_add(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] s;
        s = a + b;
        return (s > ADDR_MAX) ? ADDR_MAX : s;
    endfunction

    function automatic bit page_ceil(input logic [63:0] v, output logic [63:0] r);
        r = '0;
        if (PAGE_MASK > ADDR_MAX - v)
            return 1'b0;
        r = (v + PAGE_MASK) & ~PAGE_MASK & ADDR_MAX;
        return 1'b1;
    endfunction

    // sorted insert, after any entry with an equal base
    function automatic void table_insert(input logic [63:0] b, input logic [63:0] l);
        int pos;
        pos = 0;
        while (pos < tbl_count && tbl_base[pos] <= b)
            pos++;
        for (int i = tbl_count; i > pos; i--) begin
            tbl_base[i] = tbl_base[i-1];
            tbl_len[i]  = tbl_len[i-1];
        end
        tbl_base[pos] = b;
        tbl_len[pos]  = l;
        tbl_count++;
    endfunction

    // work out the reply to one command word and update the table copy
    function automatic void apply_region_cmd(input t_cmd c, input t_field addr,
                                             input t_field req_len);
        t_region_reply reply;
        logic [63:0]   a, l, rl, cursor, wend, b, e, gend, top;
        bit            fit, hit;
        int            idx;
        a     = {16'd0, addr};
        l     = {16'd0, req_len};
        reply = '0;
        rl    = '0;
        case (c)
            CMD_ALLOC: begin
                if (tbl_count >= REGION_SLOTS)
                    reply.status = ST_FULL;
                else if (!page_ceil(l, rl))
                    reply.status = ST_NOSPACE;
                else begin
                    cursor = win_base;
                    wend   = clip_add(win_base, win_len);
                    fit    = 1'b0;
                    for (int i = 0; i < tbl_count && !fit; i++) begin
                        b    = tbl_base[i];
                        e    = clip_add(b, tbl_len[i]);
                        gend = (b < wend) ? b : wend;
                        if (gend >= cursor && gend - cursor >= rl)
                            fit = 1'b1;
                        else if (e > cursor)
                            cursor = e;
                    end
                    // tail gap after the last region
                    if (!fit && !(wend >= cursor && wend - cursor >= rl))
                        reply.status = ST_NOSPACE;
                    else begin
                        table_insert(cursor, rl);
                        reply.status = ST_OK;
                        reply.base   = cursor[47:0];
                        reply.length = rl[47:0];
                    end
                end
            end
            CMD_ALLOC_AT: begin
                if (tbl_count >= REGION_SLOTS)
                    reply.status = ST_FULL;
                else if (l > ADDR_MAX - a)
                    reply.status = ST_NOSPACE;
                else if (!page_ceil(a + l, top))
                    reply.status = ST_NOSPACE;
                else begin
                    cursor = a & ~PAGE_MASK;
                    hit    = 1'b0;
                    for (int i = 0; i < tbl_count; i++) begin
                        e = clip_add(tbl_base[i], tbl_len[i]);
                        if (cursor < e && top > tbl_base[i])
                            hit = 1'b1;
                    end
                    if (hit)
                        reply.status = ST_NOSPACE;
                    else begin
                        rl = top - cursor;
                        table_insert(cursor, rl);
                        reply.status = ST_OK;
                        reply.base   = cursor[47:0];
                        reply.length = rl[47:0];
                    end
                end
            end
            CMD_FREE: begin
                idx = -1;
                for (int i = 0; i < tbl_count && idx < 0; i++)
                    if (tbl_base[i] == a)
                        idx = i;
                if (idx < 0)
                    reply.status = ST_NOTFOUND;
                else begin
                    for (int j = idx; j + 1 < tbl_count; j++) begin
                        tbl_base[j] = tbl_base[j+1];
                        tbl_len[j]  = tbl_len[j+1];
                    end
                    tbl_count--;
                    reply.status = ST_OK;
                end
            end
            default: reply.status = ST_NOSPACE;
        endcase
        region_reply_q.push_back(reply);
    endfunction

    function automatic void check_reply();
        t_region_reply want;
        if (region_reply_q.size() == 0) begin
            $error("result word with nothing outstanding: status %0d base %h length %h",
                   i_status, i_region_base, i_region_length);
            fail_total++;
            return;
        end
        want = region_reply_q.pop_front();
        if (want.status !== i_status) begin
            $error("status: expected %0d, got %0d", want.status, i_status);
            fail_total++;
        end
        if (want.base !== i_region_base) begin
            $error("region_base: expected %h, got %h", want.base, i_region_base);
            fail_total++;
        end
        if (want.length !== i_region_length) begin
            $error("region_length: expected %h, got %h", want.length, i_region_length);
            fail_total++;
        end
    endfunction

    // inputs sampled at the edge, before any update lands
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            tbl_count = 0;
            win_base  = '0;
            win_len   = '0;
            region_reply_q.delete();
        end else begin
            if (i_done)
                check_reply();
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_WINDOW_BASE)
                    win_base = {16'd0, i_cfg_wdata};
                else if (i_cfg_index == CFG_WINDOW_LENGTH)
                    win_len = {16'd0, i_cfg_wdata};
            end
            if (i_start && !i_busy)
                apply_region_cmd(i_cmd, i_req_address, i_req_length);
        end
        o_pending    <= region_reply_q.size();
        o_fail_count <= fail_total;
    end

endmodule

FILE: bench/tb_first_fit_region_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_first_fit_region_allocator
// Drives allocate, allocate-at and free words into the region allocator
// across several address windows; a side checker predicts each result word.
// ----------------------------------------------------------------------------
module tb_first_fit_region_allocator;
    import ffra_pkg::*;

    localparam t_cmd   CMD_UNUSED = 2'd3;          // no such command, answers no space
    localparam t_field ADDR_TOP   = 48'hFFFF_FFFF_FFFF;
    localparam int     PAGE       = 4096;

    logic     i_clk   = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     start   = 1'b0;
    logic     busy;
    t_cmd     i_cmd           = CMD_ALLOC;
    t_field   i_req_address   = '0;
    t_field   i_req_length    = '0;
    logic     o_done;
    t_status  o_status;
    t_field   o_region_base;
    t_field   o_region_length;
    logic     i_cfg_we    = 1'b0;
    t_cfg_idx i_cfg_index = CFG_WINDOW_BASE;
    t_field   i_cfg_wdata = '0;

    int       fail_count;
    int       pending;

    // current window base, for aiming addresses
    t_field   win_base;
    // bases handed back by successful allocations, reused for frees
    t_field   live_bases[$];
    // set while a stretch of back-to-back words is running
    bit       no_idle = 1'b0;

    always #5 i_clk = ~i_clk;

    first_fit_region_allocator DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_cmd           (i_cmd),
        .i_req_address   (i_req_address),
        .i_req_length    (i_req_length),
        .o_done          (o_done),
        .o_status        (o_status),
        .o_region_base   (o_region_base),
        .o_region_length (o_region_length),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    ffra_region_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (start),
        .i_busy          (busy),
        .i_cmd           (i_cmd),
        .i_req_address   (i_req_address),
        .i_req_length    (i_req_length),
        .i_done          (o_done),
        .i_status        (o_status),
        .i_region_base   (o_region_base),
        .i_region_length (o_region_length),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_wdata     (i_cfg_wdata),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    // Remember where regions landed so frees and allocate-at words can
    // hit existing bases instead of missing most of the time.
    always @(posedge i_clk) begin
        if (i_rst_n && o_done && o_status == ST_OK &&
            (o_region_base != '0 || o_region_length != '0)) begin
            live_bases.push_back(o_region_base);
            if (live_bases.size() > 24)
                void'(live_bases.pop_front());
        end
    end

    function automatic t_field rand48();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[47:0];
    endfunction

    // mostly no gap, often a short one, now and then a long one
    function automatic int idle_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic t_field pick_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return t_field'($urandom_range(0, 6 * PAGE));
        if (r < 75) return t_field'($urandom_range(0, 64 * PAGE));
        if (r < 88) return rand48() >> $urandom_range(0, 47);
        if (r < 95) return rand48();
        return ADDR_TOP - t_field'($urandom_range(0, 2 * PAGE));   // rounding overflow
    endfunction

    function automatic t_field pick_known_base();
        if (live_bases.size() == 0)
            return win_base;
        return live_bases[$urandom_range(0, live_bases.size() - 1)];
    endfunction

    function automatic t_field pick_address(input t_cmd c);
        int r;
        r = $urandom_range(0, 99);
        if (c == CMD_FREE) begin
            if (r < 70) return pick_known_base();
            if (r < 85) return win_base + t_field'($urandom_range(0, 64) * PAGE);
            return rand48();
        end
        if (r < 45)
            return win_base + t_field'($urandom_range(0, 64) * PAGE)
                            + t_field'($urandom_range(0, PAGE - 1));
        if (r < 65) return pick_known_base() + t_field'($urandom_range(0, 2 * PAGE));
        if (r < 80) return rand48() >> $urandom_range(0, 47);
        return rand48();
    endfunction

    // Present one word and hold it until taken. start stays high when the
    // next word follows with no gap, so it is never dropped and raised in
    // the same step.
    task automatic send_word(input t_cmd c, input t_field addr, input t_field len);
        int gap;
        start         <= 1'b1;
        i_cmd         <= c;
        i_req_address <= addr;
        i_req_length  <= len;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        gap = idle_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // wait for every outstanding result, then for the block to go idle
    task automatic settle();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
    endtask

    task automatic set_window(input t_field base, input t_field len);
        win_base    = base;
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_WINDOW_BASE;
        i_cfg_wdata <= base;
        @(posedge i_clk);
        i_cfg_index <= CFG_WINDOW_LENGTH;
        i_cfg_wdata <= len;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic run_phase(input t_field base, input t_field len, input int words,
                             input int alloc_pct);
        int   r;
        t_cmd c;
        set_window(base, len);
        no_idle = ($urandom_range(0, 3) == 0);
        for (int n = 0; n < words; n++) begin
            if ($urandom_range(0, 24) == 0)
                no_idle = !no_idle;
            r = $urandom_range(0, 99);
            if (r < alloc_pct)
                c = CMD_ALLOC;
            else if (r >= 96)
                c = CMD_UNUSED;
            else if (r % 2 == 0)
                c = CMD_ALLOC_AT;
            else
                c = CMD_FREE;
            send_word(c, pick_address(c), pick_length());
        end
        no_idle = 1'b0;
        settle();
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // ---- directed: small eight-page window at 0x10000 ----
        set_window(48'h1_0000, 48'h8000);
        send_word(CMD_ALLOC, '0, 48'd0);                 // zero length region
        send_word(CMD_ALLOC, '0, 48'd1);                 // same base, sorts after it
        send_word(CMD_ALLOC, ADDR_TOP, 48'h1001);        // rounds to two pages
        send_word(CMD_ALLOC_AT, 48'h1_3800, 48'h10);     // widened to page bounds
        send_word(CMD_ALLOC_AT, 48'h1_1FFF, 48'd1);      // overlaps, refused
        send_word(CMD_ALLOC, '0, ADDR_TOP);              // length rounding overflow
        send_word(CMD_ALLOC_AT, ADDR_TOP, 48'd1);        // address plus length wraps
        send_word(CMD_ALLOC_AT, ADDR_TOP - 48'h10, 48'd0); // end rounding overflow
        send_word(CMD_ALLOC_AT, 48'h9_0000, 48'h1000);   // outside window, allowed
        send_word(CMD_ALLOC, '0, 48'h1_0000);            // larger than any gap
        send_word(CMD_UNUSED, ADDR_TOP, ADDR_TOP);
        send_word(CMD_FREE, 48'h1_0000, ADDR_TOP);       // first of equal bases
        send_word(CMD_FREE, 48'h1_0000, '0);
        send_word(CMD_FREE, 48'h1_0000, '0);             // nothing left there
        send_word(CMD_ALLOC, '0, 48'h800);
        // fill the table, then both allocate commands must see it full
        for (int k = 0; k < 12; k++)
            send_word(CMD_ALLOC_AT, 48'hA_0000 + t_field'(k * 2 * PAGE), t_field'(k * 300));
        send_word(CMD_ALLOC, '0, '0);
        send_word(CMD_ALLOC_AT, 48'h20_0000, 48'h1000);
        settle();

        // ---- random phases across window settings, extremes included ----
        run_phase('0, '0, 58, 30);                            // empty window
        run_phase(ADDR_TOP, ADDR_TOP, 58, 35);                // end saturates at once
        run_phase('0, ADDR_TOP, 58, 40);                      // whole address space
        run_phase(ADDR_TOP - 48'hF_FFFF, 48'h20_0000, 58, 45); // window runs off the top
        run_phase((rand48() >> 8) & ~t_field'(PAGE - 1),
                  t_field'($urandom_range(1, 64) * PAGE), 58, 45);
        run_phase(rand48(), rand48(), 58, 40);
        run_phase(48'h1_0000, 48'h4_0000, 60, 65);             // alloc heavy, fills up

        repeat (50) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/ffra_pkg.sv
rtl/first_fit_region_allocator.sv
bench/ffra_region_checker.sv
bench/tb_first_fit_region_allocator.sv
